// ----- rtl/pec_pkg.sv -----
// Shared types, constants and elaboration-time helpers for the power ease curve.
// No dependencies.
package pec_pkg;

    localparam int FRAC_BITS = 16;
    localparam int UNIT_W    = FRAC_BITS + 1;
    localparam int EXP_W     = 13;
    localparam int EXP_FRAC  = 8;
    localparam int HP_BITS   = 30;
    localparam int LOG_W     = 21;
    localparam int T_W       = 26;

    localparam logic [UNIT_W-1:0] UNIT_ONE = UNIT_W'(1) << FRAC_BITS;
    localparam logic [EXP_W-1:0]  EXP_ONE  = EXP_W'(1) << EXP_FRAC;
    // beyond this whole part the Q30 result always shifts out to zero
    localparam logic [9:0]        WHOLE_ZERO = 10'd50;

    localparam logic CFG_EXPONENT   = 1'b0;
    localparam logic CFG_EASE_POINT = 1'b1;

    typedef struct packed {
        logic              upper;
        logic [UNIT_W-1:0] den;
        logic [EXP_W-1:0]  e;
    } t_side;

    typedef struct packed {
        t_side             side;
        logic              bypass;
        logic [UNIT_W-1:0] r;
    } t_carry;

    function automatic logic [63:0] f_isqrt(input logic [63:0] v);
        logic [63:0] val;
        logic [63:0] res;
        logic [63:0] b;
        val = v;
        res = '0;
        b   = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (val >= res + b) begin
                val = val - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // Q30 factor 2^(-2^-i), i from 1
    function automatic logic [63:0] f_exp_factor(input int idx);
        logic [63:0] c;
        c = f_isqrt(64'd1 << (2 * HP_BITS - 1));
        for (int j = 1; j < idx; j++) begin
            c = f_isqrt(c << HP_BITS);
        end
        return c;
    endfunction

endpackage

// ----- rtl/power_ease_curve_core.sv -----
// Power ease curve: eased value y(x) = k*(x/k)^e below the ease point k and
// 1-(1-k)*((1-x)/(1-k))^e above it, all in Q1.16, e in Q5.8.
// Depends on pec_pkg, pec_div, pec_log and pec_exp.
//
// One request is taken every cycle the pipeline is not held. There are 56 register stages: 1 input stage,
// 17 divider stages, 20 log and scale stages, 17 exp stages and 1 output stage.
// The whole pipeline holds while a waiting result is stalled, so throughput is
// one result per cycle the sink does not stall.
// Configuration may only be written while the pipeline is empty.
module power_ease_curve_core
    import pec_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic [UNIT_W-1:0] i_cfg_data,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [UNIT_W-1:0] i_position,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [UNIT_W-1:0] o_curve_value
);

    logic [EXP_W-1:0]  r_exponent;
    logic [UNIT_W-1:0] r_ease;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exponent <= EXP_ONE;
            r_ease     <= UNIT_W'(1) << (FRAC_BITS - 1);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_EXPONENT:   r_exponent <= i_cfg_data[EXP_W-1:0];
                CFG_EASE_POINT: r_ease     <= i_cfg_data;
                default:        ;
            endcase
        end
    end

    logic w_en;
    logic r_out_v;
    assign w_en    = !(r_out_v && i_stall);
    assign o_stall = !w_en;

    // input stage: clamp and pick the branch
    logic [UNIT_W-1:0] w_x, w_k;
    logic [EXP_W-1:0]  w_e;
    logic              w_upper;
    logic              r_in_v;
    logic [UNIT_W-1:0] r_in_num;
    t_side             r_in_side;

    assign w_x     = (i_position > UNIT_ONE) ? UNIT_ONE : i_position;
    assign w_e     = (r_exponent < EXP_ONE) ? EXP_ONE : r_exponent;
    assign w_k     = (r_ease == '0) ? UNIT_W'(1)
                   : (r_ease >= UNIT_ONE) ? UNIT_ONE - UNIT_W'(1) : r_ease;
    assign w_upper = w_x > w_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (w_en) begin
            r_in_v <= i_valid;
        end
        if (w_en) begin
            r_in_num        <= w_upper ? UNIT_ONE - w_x : w_x;
            r_in_side.upper <= w_upper;
            r_in_side.den   <= w_upper ? UNIT_ONE - w_k : w_k;
            r_in_side.e     <= w_e;
        end
    end

    logic              w_div_v;
    logic [UNIT_W-1:0] w_div_r;
    t_side             w_div_side;

    pec_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_in_v),
        .i_num   (r_in_num),
        .i_side  (r_in_side),
        .o_valid (w_div_v),
        .o_r     (w_div_r),
        .o_side  (w_div_side)
    );

    logic           w_log_v;
    logic [T_W-1:0] w_log_t;
    t_carry         w_log_c;

    pec_log u_log (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_div_v),
        .i_r     (w_div_r),
        .i_side  (w_div_side),
        .o_valid (w_log_v),
        .o_t     (w_log_t),
        .o_carry (w_log_c)
    );

    logic              w_exp_v;
    logic [UNIT_W-1:0] w_exp_p;
    t_side             w_exp_side;

    pec_exp u_exp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_log_v),
        .i_t     (w_log_t),
        .i_carry (w_log_c),
        .o_valid (w_exp_v),
        .o_p     (w_exp_p),
        .o_side  (w_exp_side)
    );

    // output stage: scale by k or 1-k
    logic [2*UNIT_W-1:0] w_scaled;
    logic [UNIT_W-1:0]   w_part, w_y;
    logic [UNIT_W-1:0]   r_out_y;

    assign w_scaled = w_exp_side.den * w_exp_p;
    assign w_part   = w_scaled[FRAC_BITS +: UNIT_W];
    assign w_y      = w_exp_side.upper ? ((w_part > UNIT_ONE) ? '0 : UNIT_ONE - w_part)
                    : ((w_part > UNIT_ONE) ? UNIT_ONE : w_part);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_en) begin
            r_out_v <= w_exp_v;
        end
        if (w_en) begin
            r_out_y <= w_y;
        end
    end

    assign o_valid       = r_out_v;
    assign o_curve_value = r_out_y;

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_curve_value <= UNIT_ONE)
        else $error("curve value above 1.0");

    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_v |-> (r_in_side.den != '0 && r_in_num <= r_in_side.den))
        else $error("divider operands out of range");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> $stable(r_in_num) && $stable(r_in_v))
        else $error("input stage moved while held");

endmodule

// ----- rtl/pec_div.sv -----
// Pipelined restoring divider, one quotient bit per stage: r = num * 2^16 / den.
// Depends on pec_pkg.
module pec_div
    import pec_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [UNIT_W-1:0] i_num,
    input  t_side             i_side,
    output logic              o_valid,
    output logic [UNIT_W-1:0] o_r,
    output t_side             o_side
);

    logic              r_v    [UNIT_W];
    logic [UNIT_W-1:0] r_rem  [UNIT_W];
    logic [UNIT_W-1:0] r_q    [UNIT_W];
    t_side             r_side [UNIT_W];

    for (genvar s = 0; s < UNIT_W; s++) begin : g_stage
        logic [UNIT_W:0]   w_rem;
        logic [UNIT_W-1:0] w_q;
        t_side             w_side;
        logic              w_v;
        logic              w_ge;
        logic [UNIT_W:0]   w_diff;

        if (s == 0) begin : g_first
            assign w_rem  = {1'b0, i_num};
            assign w_q    = '0;
            assign w_side = i_side;
            assign w_v    = i_valid;
        end else begin : g_next
            assign w_rem  = {r_rem[s-1], 1'b0};
            assign w_q    = r_q[s-1];
            assign w_side = r_side[s-1];
            assign w_v    = r_v[s-1];
        end

        assign w_ge   = w_rem >= {1'b0, w_side.den};
        assign w_diff = w_rem - {1'b0, w_side.den};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (i_en) begin
                r_v[s] <= w_v;
            end
            if (i_en) begin
                r_rem[s]  <= w_ge ? w_diff[UNIT_W-1:0] : w_rem[UNIT_W-1:0];
                r_q[s]    <= w_q | (UNIT_W'(w_ge) << (UNIT_W - 1 - s));
                r_side[s] <= w_side;
            end
        end
    end

    assign o_valid = r_v[UNIT_W-1];
    assign o_r     = r_q[UNIT_W-1];
    assign o_side  = r_side[UNIT_W-1];

endmodule

// ----- rtl/pec_log.sv -----
// Pipelined -log2 by repeated squaring, then scaling by the exponent: t = (L*e) >> 8.
// Depends on pec_pkg.
module pec_log
    import pec_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [UNIT_W-1:0] i_r,
    input  t_side             i_side,
    output logic              o_valid,
    output logic [T_W-1:0]    o_t,
    output t_carry            o_carry
);

    // leading-one search
    logic              r_a_v;
    logic [3:0]        r_a_p;
    t_carry            r_a_c;
    logic [3:0]        n_a_p;

    always_comb begin
        n_a_p = '0;
        for (int i = 0; i < FRAC_BITS; i++) begin
            if (i_r[i]) begin
                n_a_p = 4'(i);
            end
        end
    end

    // normalise
    logic              r_b_v;
    logic [4:0]        r_b_n;
    logic [UNIT_W-1:0] r_b_m;
    t_carry            r_b_c;
    logic [4:0]        n_b_n;

    assign n_b_n = 5'(FRAC_BITS) - {1'b0, r_a_p};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
        end else if (i_en) begin
            r_a_v <= i_valid;
            r_b_v <= r_a_v;
        end
        if (i_en) begin
            r_a_p             <= n_a_p;
            r_a_c.side        <= i_side;
            r_a_c.r           <= i_r;
            r_a_c.bypass      <= (i_r == '0) || i_r[FRAC_BITS] || (i_side.e == EXP_ONE);
            r_b_n             <= n_b_n;
            r_b_m             <= UNIT_W'(r_a_c.r << n_b_n);
            r_b_c             <= r_a_c;
        end
    end

    // squaring stages, one fraction bit each
    logic              r_s_v    [FRAC_BITS];
    logic [UNIT_W-1:0] r_s_m    [FRAC_BITS];
    logic [FRAC_BITS-1:0] r_s_f [FRAC_BITS];
    logic [4:0]        r_s_n    [FRAC_BITS];
    t_carry            r_s_c    [FRAC_BITS];

    for (genvar j = 0; j < FRAC_BITS; j++) begin : g_sq
        logic              w_v;
        logic [UNIT_W-1:0] w_m;
        logic [FRAC_BITS-1:0] w_f;
        logic [4:0]        w_n;
        t_carry            w_c;
        logic [2*UNIT_W-1:0] w_sq;
        logic [UNIT_W:0]   w_top;

        if (j == 0) begin : g_first
            assign w_v = r_b_v;
            assign w_m = r_b_m;
            assign w_f = '0;
            assign w_n = r_b_n;
            assign w_c = r_b_c;
        end else begin : g_next
            assign w_v = r_s_v[j-1];
            assign w_m = r_s_m[j-1];
            assign w_f = r_s_f[j-1];
            assign w_n = r_s_n[j-1];
            assign w_c = r_s_c[j-1];
        end

        assign w_sq  = w_m * w_m;
        assign w_top = w_sq[FRAC_BITS +: UNIT_W + 1];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_s_v[j] <= 1'b0;
            end else if (i_en) begin
                r_s_v[j] <= w_v;
            end
            if (i_en) begin
                r_s_m[j] <= w_top[UNIT_W] ? w_top[UNIT_W:1] : w_top[UNIT_W-1:0];
                r_s_f[j] <= {w_f[FRAC_BITS-2:0], w_top[UNIT_W]};
                r_s_n[j] <= w_n;
                r_s_c[j] <= w_c;
            end
        end
    end

    // L = n*2^16 - frac, then scale
    logic              r_l_v;
    logic [LOG_W-1:0]  r_l;
    t_carry            r_l_c;
    logic              r_t_v;
    logic [T_W-1:0]    r_t;
    t_carry            r_t_c;
    logic [LOG_W+EXP_W-1:0] w_prod;

    assign w_prod = r_l * r_l_c.side.e;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_l_v <= 1'b0;
            r_t_v <= 1'b0;
        end else if (i_en) begin
            r_l_v <= r_s_v[FRAC_BITS-1];
            r_t_v <= r_l_v;
        end
        if (i_en) begin
            r_l   <= {r_s_n[FRAC_BITS-1], {FRAC_BITS{1'b0}}}
                     - {5'd0, r_s_f[FRAC_BITS-1]};
            r_l_c <= r_s_c[FRAC_BITS-1];
            r_t   <= w_prod[EXP_FRAC +: T_W];
            r_t_c <= r_l_c;
        end
    end

    assign o_valid = r_t_v;
    assign o_t     = r_t;
    assign o_carry = r_t_c;

endmodule

// ----- rtl/pec_exp.sv -----
// Pipelined 2^-t: one Q30 factor multiply per fraction bit, then the whole-part shift.
// Depends on pec_pkg.
module pec_exp
    import pec_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [T_W-1:0]    i_t,
    input  t_carry            i_carry,
    output logic              o_valid,
    output logic [UNIT_W-1:0] o_p,
    output t_side             o_side
);

    logic                 r_v   [FRAC_BITS];
    logic [HP_BITS:0]     r_acc [FRAC_BITS];
    logic [T_W-1:0]       r_t   [FRAC_BITS];
    t_carry               r_c   [FRAC_BITS];

    for (genvar i = 0; i < FRAC_BITS; i++) begin : g_mul
        localparam logic [HP_BITS-1:0] C = HP_BITS'(f_exp_factor(i + 1));
        logic             w_v;
        logic [HP_BITS:0] w_acc;
        logic [T_W-1:0]   w_t;
        t_carry           w_c;
        logic [2*HP_BITS:0] w_prod;

        if (i == 0) begin : g_first
            assign w_v   = i_valid;
            assign w_acc = (HP_BITS + 1)'(1) << HP_BITS;
            assign w_t   = i_t;
            assign w_c   = i_carry;
        end else begin : g_next
            assign w_v   = r_v[i-1];
            assign w_acc = r_acc[i-1];
            assign w_t   = r_t[i-1];
            assign w_c   = r_c[i-1];
        end

        assign w_prod = w_acc * {1'b0, C};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i] <= 1'b0;
            end else if (i_en) begin
                r_v[i] <= w_v;
            end
            if (i_en) begin
                r_acc[i] <= w_t[FRAC_BITS-1-i] ? w_prod[HP_BITS +: HP_BITS + 1] : w_acc;
                r_t[i]   <= w_t;
                r_c[i]   <= w_c;
            end
        end
    end

    logic              r_o_v;
    logic [UNIT_W-1:0] r_o_p;
    t_side             r_o_side;
    logic [9:0]        w_whole;
    logic [5:0]        w_sh;
    logic [HP_BITS:0]  w_shifted;
    logic [UNIT_W-1:0] w_pow;

    assign w_whole   = r_t[FRAC_BITS-1][FRAC_BITS +: 10];
    assign w_sh      = 6'(HP_BITS - FRAC_BITS) + w_whole[5:0];
    assign w_shifted = r_acc[FRAC_BITS-1] >> w_sh;
    assign w_pow     = (w_whole >= WHOLE_ZERO) ? '0 : w_shifted[UNIT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (i_en) begin
            r_o_v <= r_v[FRAC_BITS-1];
        end
        if (i_en) begin
            r_o_p    <= r_c[FRAC_BITS-1].bypass ? r_c[FRAC_BITS-1].r : w_pow;
            r_o_side <= r_c[FRAC_BITS-1].side;
        end
    end

    assign o_valid = r_o_v;
    assign o_p     = r_o_p;
    assign o_side  = r_o_side;

endmodule

// ----- verif/tb_power_ease_curve_core.sv -----
`timescale 1ns / 1ps
// Testbench for power_ease_curve_core: directed table then random positions,
// checked against an in-bench fixed-point model of the eased curve.
// Depends on pec_pkg and the power_ease_curve_core RTL.
module tb_power_ease_curve_core;
    import pec_pkg::*;

    localparam int LATENCY = 56;
    localparam longint CYCLE_LIMIT = 400000;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic              i_cfg_index;
    logic [UNIT_W-1:0] i_cfg_data;
    logic              i_valid;
    logic              o_stall;
    logic [UNIT_W-1:0] i_position;
    logic              o_valid;
    logic              i_stall;
    logic [UNIT_W-1:0] o_curve_value;

    power_ease_curve_core u_top (.*);

    // the block's own register copies
    logic [EXP_W-1:0]  exponent_reg;
    logic [UNIT_W-1:0] ease_reg;

    logic [UNIT_W-1:0] curve_q[$];
    int                errors;
    longint            cycles;
    int                hold_off;    // long sink hold-off, in cycles

    typedef struct {
        logic [UNIT_W-1:0] pos;
        int                want;    // -1: use the model
    } t_row;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d want %0d", what, got, want);
        errors++;
    endtask

    function automatic longint unsigned isqrt64(input longint unsigned v);
        longint unsigned res, b;
        res = 0;
        b   = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (v >= res + b) begin
                v   = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // r^e as 2^-(e * -log2 r), r in QF
    function automatic longint unsigned ratio_pow(input longint unsigned num,
            input longint unsigned den, input longint unsigned e);
        longint unsigned r, m, fr, lg, t, acc, c, sh;
        int unsigned lead;
        r = (num << FRAC_BITS) / den;
        if (r > (64'd1 << FRAC_BITS)) r = 64'd1 << FRAC_BITS;
        if (r == 0) return 0;
        if (r == (64'd1 << FRAC_BITS) || e == EXP_ONE) return r;
        lead = 0;
        for (int i = 0; i < FRAC_BITS; i++) if (r[i]) lead = i;
        m  = r << (FRAC_BITS - lead);
        fr = 0;
        for (int i = 0; i < FRAC_BITS; i++) begin
            m  = (m * m) >> FRAC_BITS;
            fr = fr << 1;
            if (m >= (64'd2 << FRAC_BITS)) begin
                fr = fr | 1;
                m  = m >> 1;
            end
        end
        lg  = longint'(FRAC_BITS - lead) * (64'd1 << FRAC_BITS) - fr;
        t   = (lg * e) >> EXP_FRAC;
        acc = 64'd1 << HP_BITS;
        c   = isqrt64(64'd1 << (2 * HP_BITS - 1));
        for (int i = 1; i <= FRAC_BITS; i++) begin
            if (t[FRAC_BITS-i]) acc = (acc * c) >> HP_BITS;
            c = isqrt64(c << HP_BITS);
        end
        sh = (HP_BITS - FRAC_BITS) + (t >> FRAC_BITS);
        if (sh >= 64) return 0;
        return acc >> sh;
    endfunction

    function automatic logic [UNIT_W-1:0] eased_value(input logic [UNIT_W-1:0] pos);
        longint unsigned x, e, k, p, y, span, drop, one;
        one = 64'd1 << FRAC_BITS;
        x = pos;
        e = exponent_reg;
        k = ease_reg;
        if (x > one) x = one;
        if (e < EXP_ONE) e = EXP_ONE;
        if (k < 1) k = 1;
        if (k > one - 1) k = one - 1;
        if (x <= k) begin
            p = ratio_pow(x, k, e);
            y = (k * p) >> FRAC_BITS;
        end else begin
            span = one - k;
            p    = ratio_pow(one - x, span, e);
            drop = (span * p) >> FRAC_BITS;
            y    = drop > one ? 0 : one - drop;
        end
        if (y > one) y = one;
        return UNIT_W'(y);
    endfunction

    task automatic tick();
        @(posedge i_clk);
    endtask

    // offer one request and hold it until taken
    task automatic send_position(input logic [UNIT_W-1:0] pos, input int want);
        logic [UNIT_W-1:0] exp_val;
        exp_val = eased_value(pos);
        if (want >= 0 && exp_val != UNIT_W'(want))
            report_mismatch("table", exp_val, want);
        i_valid    <= 1'b1;
        i_position <= pos;
        do tick(); while (o_stall);
        curve_q.push_back(exp_val);
    endtask

    task automatic random_gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
        if ($urandom_range(0, 2) == 0) n = 0;
        if (n > 0) begin
            i_valid    <= 1'b0;
            i_position <= UNIT_W'($urandom);
            repeat (n) tick();
        end
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (curve_q.size() != 0) tick();
        repeat (LATENCY + 4) tick();
    endtask

    task automatic write_cfg(input logic idx, input logic [UNIT_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        tick();
        i_cfg_we <= 1'b0;
        if (idx == CFG_EXPONENT) exponent_reg = val[EXP_W-1:0];
        else ease_reg = val;
    endtask

    function automatic logic [UNIT_W-1:0] rand_position();
        case ($urandom_range(0, 5))
            0: return UNIT_W'($urandom);                       // incl. oversized
            1: return UNIT_W'($urandom_range(0, 8));
            2: return UNIT_W'($urandom_range(65528, 65536));
            3: return UNIT_W'(ease_reg + UNIT_W'($urandom_range(0, 4)) - 2);
            default: return UNIT_W'($urandom_range(0, 65536));
        endcase
    endfunction

    // sink: random stall with a long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            i_stall  <= 1'b1;
        end else if ($urandom_range(0, 3) == 0) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= ($urandom_range(0, 15) == 0) ? 1'b1 : ($urandom_range(0, 3) == 0);
        end
    end

    // checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (curve_q.size() == 0) begin
                report_mismatch("unexpected curve_value", o_curve_value, -1);
            end else begin
                if (o_curve_value !== curve_q[0])
                    report_mismatch("curve_value", o_curve_value, curve_q[0]);
                void'(curve_q.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    t_row table_rows[$];
    logic [UNIT_W-1:0] exps[6]  = '{17'd256, 17'd0, 17'd8191, 17'd512, 17'd300, 17'd1000};
    logic [UNIT_W-1:0] eases[6] = '{17'd32768, 17'd0, 17'd65536, 17'd1, 17'd65535, 17'd20000};

    initial begin
        errors      = 0;
        cycles      = 0;
        hold_off    = 0;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = CFG_EXPONENT;
        i_cfg_data  = '0;
        i_valid     = 1'b0;
        i_position  = '0;
        exponent_reg = 13'd256;
        ease_reg     = 17'd32768;
        repeat (4) tick();
        i_rst_n <= 1'b1;
        tick();

        // after reset the curve is linear: y = x, oversized saturates
        table_rows = '{'{17'd0, 0}, '{17'd65536, 65536}, '{17'd131071, 65536},
                       '{17'd32768, 32768}, '{17'd12345, 12345}, '{17'd65535, 65535},
                       '{17'd1, 1}, '{17'd100000, 65536}, '{17'd32769, -1}};
        foreach (table_rows[i]) send_position(table_rows[i].pos, table_rows[i].want);
        drain();
        // steep exponent: ends still pinned, middle from the model
        write_cfg(CFG_EXPONENT, 17'd8191);
        table_rows = '{'{17'd0, 0}, '{17'd65536, 65536}, '{17'd131071, 65536},
                       '{17'd32768, 32768}, '{17'd1, -1}, '{17'd16384, -1},
                       '{17'd49152, -1}, '{17'd65535, -1}};
        foreach (table_rows[i]) send_position(table_rows[i].pos, table_rows[i].want);
        drain();
        // ease point clamped at both ends
        write_cfg(CFG_EASE_POINT, 17'd0);
        send_position(17'd0, 0);
        send_position(17'd40000, -1);
        drain();
        write_cfg(CFG_EASE_POINT, 17'd65536);
        send_position(17'd65536, 65536);
        send_position(17'd65535, -1);
        send_position(17'd40000, -1);
        drain();

        // random phases over settings; second phase holds the sink off
        for (int ph = 0; ph < 12; ph++) begin
            write_cfg(CFG_EXPONENT, (ph < 6) ? exps[ph] : UNIT_W'($urandom_range(0, 8191)));
            write_cfg(CFG_EASE_POINT, (ph < 6) ? eases[ph] : UNIT_W'($urandom_range(0, 65536)));
            if (ph == 1) hold_off = 200;
            for (int n = 0; n < 50; n++) begin
                send_position(rand_position(), -1);
                if (ph != 1) random_gap();
            end
            drain();
        end

        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/pec_pkg.sv
rtl/pec_div.sv
rtl/pec_log.sv
rtl/pec_exp.sv
rtl/power_ease_curve_core.sv
verif/tb_power_ease_curve_core.sv
